@@ src/tpcl_pkg.sv @@
// Package for the threshold promote cache list: sizes, widths and cell control type.
`default_nettype none
package tpcl_pkg;

    // List geometry
    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 64;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int USED_W      = $clog2(MAX_ENTRIES + 1);

    // Fixed field widths
    localparam int COUNT_W     = 16;
    localparam int THR_W       = 16;
    localparam int CAP_W       = 5;
    localparam int POS_W       = 4;
    localparam int OCC_W       = 5;
    localparam int KEY_PORT_W  = 64;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes on func
    localparam logic FUNC_ACCESS = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HIT_THRESHOLD = 1'b0;
    localparam logic CFG_CAPACITY      = 1'b1;

    // Per-cell update command
    typedef struct packed {
        logic load_new;   // take key and count from the front input
        logic shift;      // take key and count from the neighbor toward the front
        logic set_count;  // update the count only
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ src/tpcl_cell.sv @@
// One list slot: holds a key and its hit count, compares against the access key.
`default_nettype none
module tpcl_cell (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire  tpcl_pkg::cell_ctrl_t        ctrl,
    input  wire                               valid,
    input  wire  [tpcl_pkg::KEY_BITS-1:0]     access_key,
    input  wire  [tpcl_pkg::COUNT_W-1:0]      new_count,
    input  wire  [tpcl_pkg::KEY_BITS-1:0]     prev_key,
    input  wire  [tpcl_pkg::COUNT_W-1:0]      prev_count,
    output logic [tpcl_pkg::KEY_BITS-1:0]     key_out,
    output logic [tpcl_pkg::COUNT_W-1:0]      count_out,
    output logic                              match
);
    import tpcl_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // Next slot contents
    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        if (ctrl.load_new)
        begin
            key_next   = access_key;
            count_next = new_count;
        end
        else if (ctrl.shift)
        begin
            key_next   = prev_key;
            count_next = prev_count;
        end
        else if (ctrl.set_count)
        begin
            count_next = new_count;
        end
    end

    // Key storage, undefined until written
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // Count storage, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign key_out   = key_reg;
    assign count_out = count_reg;
    assign match     = valid && (key_reg == access_key);

endmodule
`default_nettype wire

@@ src/threshold_promote_cache_list.sv @@
// Top level: move-to-front cache list with hit threshold, built as a row of slot cells.
// A result strobes on done in the cycle after start is taken.
// Throughput: one access per cycle; all slots compare in parallel and shift in one step.
// busy stays low, so start is taken every cycle it is high; the receiver cannot stall.
// Reset: list empty, counts zero, hit_threshold 2, capacity 16; keys undefined until written.
// cfg_ready is always high; write configuration only while no access is in flight.
`default_nettype none
module threshold_promote_cache_list (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 func,
    input  wire  [tpcl_pkg::KEY_PORT_W-1:0]     key,
    output logic                                done,
    output logic                                hit,
    output logic [tpcl_pkg::POS_W-1:0]          hit_position,
    output logic [tpcl_pkg::COUNT_W-1:0]        hit_count,
    output logic                                promoted,
    output logic                                evicted,
    output logic [tpcl_pkg::KEY_PORT_W-1:0]     evicted_key,
    output logic [tpcl_pkg::OCC_W-1:0]          occupancy,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire                                 cfg_addr,
    input  wire  [tpcl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tpcl_pkg::*;

    // Configuration registers
    logic [THR_W-1:0]  threshold_reg;
    logic [CAP_W-1:0]  capacity_reg;

    // List state
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;

    // Result registers
    logic                  done_reg;
    logic                  hit_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  promoted_reg;
    logic                  evicted_reg;
    logic [KEY_PORT_W-1:0] evkey_reg;
    logic [OCC_W-1:0]      occ_reg;

    // Cell row wiring
    cell_ctrl_t            ctrl   [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   keys   [MAX_ENTRIES];
    logic [COUNT_W-1:0]    counts [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid;
    logic [MAX_ENTRIES-1:0] match;

    logic                  accept;
    logic [KEY_BITS-1:0]   acc_key;
    logic                  found;
    logic [IDX_W-1:0]      pos;
    logic [COUNT_W-1:0]    old_cnt;
    logic [COUNT_W-1:0]    inc_cnt;
    logic [COUNT_W-1:0]    ins_cnt;
    logic                  promote;
    logic [USED_W-1:0]     cap_eff;
    logic                  full;
    logic                  evict;
    logic [USED_W-1:0]     used_base;
    logic [KEY_BITS-1:0]   last_key;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign acc_key   = KEY_BITS'(key);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_W'(2);
            capacity_reg  <= CAP_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_HIT_THRESHOLD: threshold_reg <= cfg_data;
                CFG_CAPACITY:      capacity_reg  <= cfg_data[CAP_W-1:0];
                default:           threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Slot cells
    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic [KEY_BITS-1:0] pk;
            logic [COUNT_W-1:0]  pc;
            if (g == 0)
            begin : g_front
                assign pk = '0;
                assign pc = '0;
            end
            else
            begin : g_rest
                assign pk = keys[g-1];
                assign pc = counts[g-1];
            end
            assign valid[g] = (USED_W'(g) < used_reg);
            tpcl_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .valid      (valid[g]),
                .access_key (acc_key),
                .new_count  (ins_cnt),
                .prev_key   (pk),
                .prev_count (pc),
                .key_out    (keys[g]),
                .count_out  (counts[g]),
                .match      (match[g])
            );
        end
    endgenerate

    // Hit lookup: at most one valid slot matches, so OR-combine
    always_comb
    begin
        found   = |match;
        pos     = '0;
        old_cnt = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match[i])
            begin
                pos     = pos | IDX_W'(i);
                old_cnt = old_cnt | counts[i];
            end
        end
    end

    // Count update, promotion, capacity and eviction
    always_comb
    begin
        inc_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_W'(1);
        promote = (func == FUNC_ACCESS) && found && (pos != '0) && (inc_cnt > threshold_reg);
        if (capacity_reg == '0)
            cap_eff = USED_W'(1);
        else if (int'(capacity_reg) > MAX_ENTRIES)
            cap_eff = USED_W'(MAX_ENTRIES);
        else
            cap_eff = USED_W'(capacity_reg);
        full      = (used_reg >= cap_eff);
        evict     = (func == FUNC_ACCESS) && !found && full;
        used_base = full ? (cap_eff - USED_W'(1)) : used_reg;
        last_key  = keys[IDX_W'(used_reg - USED_W'(1))];
        ins_cnt   = ((func == FUNC_ACCESS) && found) ? inc_cnt : COUNT_W'(1);
    end

    // Per-cell commands
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ctrl[i] = '0;
            if (accept)
            begin
                if (func == FUNC_CLEAR)
                begin
                    ctrl[i].load_new = (i == 0);
                end
                else if (found && promote)
                begin
                    ctrl[i].load_new = (i == 0);
                    ctrl[i].shift    = (i != 0) && (IDX_W'(i) <= pos);
                end
                else if (found)
                begin
                    ctrl[i].set_count = (IDX_W'(i) == pos);
                end
                else
                begin
                    ctrl[i].load_new = (i == 0);
                    ctrl[i].shift    = (i != 0) && (USED_W'(i) <= used_base);
                end
            end
        end
    end

    // Occupancy after this access
    always_comb
    begin
        if (func == FUNC_CLEAR)
            used_next = USED_W'(1);
        else if (found)
            used_next = used_reg;
        else
            used_next = used_base + USED_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                used_reg <= used_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg      <= (func == FUNC_ACCESS) && found;
            pos_reg      <= ((func == FUNC_ACCESS) && found) ? POS_W'(pos) : '0;
            count_reg    <= ins_cnt;
            promoted_reg <= promote;
            evicted_reg  <= evict;
            evkey_reg    <= evict ? KEY_PORT_W'(last_key) : '0;
            occ_reg      <= OCC_W'(used_next);
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign hit_position = pos_reg;
    assign hit_count    = count_reg;
    assign promoted     = promoted_reg;
    assign evicted      = evicted_reg;
    assign evicted_key  = evkey_reg;
    assign occupancy    = occ_reg;

    // Checks
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(used_reg) <= MAX_ENTRIES)
        else $error("occupancy beyond list size");

    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("key found in more than one slot");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("transfer without result");

    a_promote_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && (promoted || hit_position != '0) |-> hit)
        else $error("promotion or position without hit");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && evicted |-> !hit && (occupancy == OCC_W'(cap_eff)))
        else $error("eviction inconsistent");

endmodule
`default_nettype wire

@@ tb/tb_threshold_promote_cache_list.sv @@
// Testbench for the threshold promote cache list: directed table, count run, random phases.
`timescale 1ns / 1ps

module tb_threshold_promote_cache_list;
    import tpcl_pkg::*;

    localparam int CYCLE_LIMIT  = 2000;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_ITEMS  = 122;
    localparam int MAX_MISMATCH_SHOWN = 10;

    // One result of an access, as the block reports it
    typedef struct packed {
        logic                 hit;
        logic [POS_W-1:0]     pos;
        logic [COUNT_W-1:0]   count;
        logic                 promoted;
        logic                 evicted;
        logic [KEY_PORT_W-1:0] ev_key;
        logic [OCC_W-1:0]     occ;
    } lookup_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  func;
        logic [KEY_PORT_W-1:0] key;
        logic                  addr;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        lookup_result_t        want;
    } dir_row_t;

    // DUT signals
    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic                   func;
    logic [KEY_PORT_W-1:0]  key;
    logic                   done;
    logic                   hit;
    logic [POS_W-1:0]       hit_position;
    logic [COUNT_W-1:0]     hit_count;
    logic                   promoted;
    logic                   evicted;
    logic [KEY_PORT_W-1:0]  evicted_key;
    logic [OCC_W-1:0]       occupancy;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_data;

    threshold_promote_cache_list u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .key          (key),
        .done         (done),
        .hit          (hit),
        .hit_position (hit_position),
        .hit_count    (hit_count),
        .promoted     (promoted),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .occupancy    (occupancy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the list and registers
    logic [KEY_BITS-1:0]  shadow_key   [MAX_ENTRIES];
    logic [COUNT_W-1:0]   shadow_count [MAX_ENTRIES];
    int                   shadow_used;
    logic [THR_W-1:0]     shadow_thr;
    logic [CAP_W-1:0]     shadow_cap;

    lookup_result_t       lookup_q[$];
    int                   mismatches;
    int                   quiet_cycles;
    bit                   idle_on;
    bit                   use_typed;
    lookup_result_t       typed_want;
    dir_row_t             dir_rows[$];
    logic [KEY_PORT_W-1:0] key_pool[$];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Slide entries 0..p-1 down one place and put k at the front
    function automatic void shift_to_front(int p, logic [KEY_BITS-1:0] k,
                                           logic [COUNT_W-1:0] c);
        int i;
        for (i = p; i > 0; i--)
        begin
            shadow_key[i]   = shadow_key[i-1];
            shadow_count[i] = shadow_count[i-1];
        end
        shadow_key[0]   = k;
        shadow_count[0] = c;
    endfunction

    // Predict one access and advance the shadow list
    function automatic lookup_result_t cache_step(logic f, logic [KEY_PORT_W-1:0] k_in);
        lookup_result_t     r;
        logic [KEY_BITS-1:0] k;
        int                 p;
        int                 ecap;
        logic [COUNT_W-1:0] c;
        bit                 found;
        k = k_in[KEY_BITS-1:0];
        r = '0;
        r.count = COUNT_W'(1);
        found = 1'b0;
        p = 0;
        if (f == FUNC_CLEAR)
        begin
            shadow_key[0]   = k;
            shadow_count[0] = COUNT_W'(1);
            shadow_used     = 1;
        end
        else
        begin
            for (int i = 0; i < shadow_used; i++)
            begin
                if (!found && shadow_key[i] == k)
                begin
                    found = 1'b1;
                    p = i;
                end
            end
            if (found)
            begin
                c = shadow_count[p];
                if (c != COUNT_MAX)
                    c = c + 1'b1;
                shadow_count[p] = c;
                r.hit   = 1'b1;
                r.pos   = p[POS_W-1:0];
                r.count = c;
                if (p != 0 && c > shadow_thr)
                begin
                    shift_to_front(p, k, c);
                    r.promoted = 1'b1;
                end
            end
            else
            begin
                ecap = int'(shadow_cap);
                if (ecap < 1)
                    ecap = 1;
                if (ecap > MAX_ENTRIES)
                    ecap = MAX_ENTRIES;
                if (shadow_used >= ecap)
                begin
                    r.evicted = 1'b1;
                    r.ev_key  = KEY_PORT_W'(shadow_key[shadow_used-1]);
                    shadow_used = ecap - 1;
                end
                shift_to_front(shadow_used, k, COUNT_W'(1));
                shadow_used++;
            end
        end
        r.occ = shadow_used[OCC_W-1:0];
        return r;
    endfunction

    // Result of an insert or a clear: plain miss with count 1
    function automatic lookup_result_t inserted_result(int occ);
        lookup_result_t r;
        r = '0;
        r.count = COUNT_W'(1);
        r.occ = occ[OCC_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t item_row(logic f, logic [KEY_PORT_W-1:0] k);
        dir_row_t row;
        row = '{ROW_ITEM, f, k, 1'b0, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic dir_row_t typed_row(logic f, logic [KEY_PORT_W-1:0] k,
                                           lookup_result_t w);
        dir_row_t row;
        row = '{ROW_ITEM, f, k, 1'b0, '0, 1'b1, w};
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic a, logic [CFG_DATA_W-1:0] d);
        dir_row_t row;
        row = '{ROW_CFG, FUNC_ACCESS, '0, a, d, 1'b0, '0};
        return row;
    endfunction

    // Random key, with the extremes now and then
    function automatic logic [KEY_PORT_W-1:0] rand_key();
        logic [KEY_PORT_W-1:0] k;
        case ($urandom_range(9))
            0: k = '0;
            1: k = '1;
            2: k = KEY_PORT_W'($urandom_range(15));
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= MAX_MISMATCH_SHOWN)
            $display("MISMATCH %s: expected %h, got %h", what, want, got);
    endtask

    task automatic check_lookup(lookup_result_t w, lookup_result_t g);
        if (w.hit !== g.hit)           note_mismatch("hit", 64'(w.hit), 64'(g.hit));
        if (w.pos !== g.pos)           note_mismatch("hit_position", 64'(w.pos), 64'(g.pos));
        if (w.count !== g.count)       note_mismatch("hit_count", 64'(w.count), 64'(g.count));
        if (w.promoted !== g.promoted) note_mismatch("promoted", 64'(w.promoted),
                                                     64'(g.promoted));
        if (w.evicted !== g.evicted)   note_mismatch("evicted", 64'(w.evicted),
                                                     64'(g.evicted));
        if (w.ev_key !== g.ev_key)     note_mismatch("evicted_key", w.ev_key, g.ev_key);
        if (w.occ !== g.occ)           note_mismatch("occupancy", 64'(w.occ), 64'(g.occ));
    endtask

    // Monitor: results, accepted accesses, register writes, watchdog
    always @(posedge clk)
    begin
        lookup_result_t got;
        lookup_result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{hit, hit_position, hit_count, promoted, evicted, evicted_key,
                        occupancy};
                if (lookup_q.size() == 0)
                    note_mismatch("result with nothing pending", 64'd0, 64'd1);
                else
                    check_lookup(lookup_q.pop_front(), got);
            end
            if (start && !busy)
            begin
                pred = cache_step(func, key);
                lookup_q.push_back(use_typed ? typed_want : pred);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == CFG_HIT_THRESHOLD)
                    shadow_thr = cfg_data[THR_W-1:0];
                else
                    shadow_cap = cfg_data[CAP_W-1:0];
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= CYCLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // One access; waits for the transfer
    task automatic send_access(logic f, logic [KEY_PORT_W-1:0] k, bit typed,
                               lookup_result_t w);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 25)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        use_typed  = typed;
        typed_want = w;
        start <= 1'b1;
        func  <= f;
        key   <= k;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (lookup_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic a, logic [CFG_DATA_W-1:0] d);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_addr  <= a;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        logic [KEY_PORT_W-1:0] sat_key;
        logic [KEY_PORT_W-1:0] k;
        int                    roll;

        rst_n       = 1'b0;
        start       = 1'b0;
        func        = FUNC_ACCESS;
        key         = '0;
        cfg_valid   = 1'b0;
        cfg_addr    = CFG_HIT_THRESHOLD;
        cfg_data    = '0;
        use_typed   = 1'b0;
        typed_want  = '0;
        idle_on     = 1'b1;
        mismatches  = 0;
        quiet_cycles = 0;
        shadow_used = 0;
        shadow_thr  = THR_W'(2);
        shadow_cap  = CAP_W'(16);
        for (int i = 0; i < MAX_ENTRIES; i++)
            shadow_count[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset state, promotion, clear, eviction, capacity corners
        dir_rows.push_back(typed_row(FUNC_ACCESS, '0, inserted_result(1)));
        dir_rows.push_back(typed_row(FUNC_ACCESS, '1, inserted_result(2)));
        dir_rows.push_back(item_row(FUNC_ACCESS, '0));
        dir_rows.push_back(item_row(FUNC_ACCESS, '0));
        dir_rows.push_back(item_row(FUNC_ACCESS, '0));
        dir_rows.push_back(item_row(FUNC_ACCESS, '1));
        dir_rows.push_back(typed_row(FUNC_CLEAR, 64'h5555_5555_5555_5555,
                                     inserted_result(1)));
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 16'd3));
        dir_rows.push_back(cfg_row(CFG_HIT_THRESHOLD, 16'd0));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd1));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd2));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA));
        // capacity dropped below occupancy: old entries still hit, a miss trims
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 16'd1));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd1));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd7));
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 16'd0));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd8));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd8));
        // upper data bits set; capacity above the list size
        dir_rows.push_back(cfg_row(CFG_CAPACITY, 16'hFFFF));
        dir_rows.push_back(cfg_row(CFG_HIT_THRESHOLD, 16'hFFFF));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd9));
        dir_rows.push_back(item_row(FUNC_ACCESS, 64'd8));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].addr, dir_rows[i].data);
            else
                send_access(dir_rows[i].func, dir_rows[i].key, dir_rows[i].typed,
                            dir_rows[i].want);
        end

        // Count run, back to back: climb from second place past the threshold
        idle_on = 1'b0;
        write_reg(CFG_HIT_THRESHOLD, 16'd5);
        write_reg(CFG_CAPACITY, 16'd16);
        sat_key = {$urandom, $urandom};
        send_access(FUNC_CLEAR, sat_key, 1'b0, '0);
        send_access(FUNC_ACCESS, ~sat_key, 1'b0, '0);
        repeat (8) send_access(FUNC_ACCESS, sat_key, 1'b0, '0);
        repeat (4) send_access(FUNC_ACCESS, ~sat_key, 1'b0, '0);
        idle_on = 1'b1;

        // Random phases: new registers and key pool each phase
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case ($urandom_range(5))
                0: write_reg(CFG_HIT_THRESHOLD, 16'd0);
                1: write_reg(CFG_HIT_THRESHOLD, 16'hFFFF);
                2: write_reg(CFG_HIT_THRESHOLD, CFG_DATA_W'($urandom));
                default: write_reg(CFG_HIT_THRESHOLD, CFG_DATA_W'($urandom_range(6)));
            endcase
            case ($urandom_range(7))
                0: write_reg(CFG_CAPACITY, 16'd1);
                1: write_reg(CFG_CAPACITY, 16'd16);
                2: write_reg(CFG_CAPACITY, 16'd0);
                3: write_reg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(31, 17)));
                default: write_reg(CFG_CAPACITY, CFG_DATA_W'($urandom_range(16, 2)));
            endcase
            key_pool.delete();
            repeat ($urandom_range(24, 2)) key_pool.push_back(rand_key());
            idle_on = (ph != 6);
            repeat (PHASE_ITEMS)
            begin
                roll = $urandom_range(99);
                k = key_pool[$urandom_range(key_pool.size() - 1)];
                if (roll < 3)
                    send_access(FUNC_CLEAR, k, 1'b0, '0);
                else if (roll < 15)
                    send_access(FUNC_ACCESS, rand_key(), 1'b0, '0);
                else
                    send_access(FUNC_ACCESS, k, 1'b0, '0);
                // occasional full drain mid-phase
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
        end

        // Wind down
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ threshold_promote_cache_list.f @@
src/tpcl_pkg.sv
src/tpcl_cell.sv
src/threshold_promote_cache_list.sv
tb/tb_threshold_promote_cache_list.sv
